// ----- rtl/core/fdp_pkg.sv -----
package fdp_pkg;

  localparam int CKS_W = 32;
  localparam int SZ_W  = 21;
  localparam int IDX_W = 32;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam logic [SZ_W-1:0] BLOCK_LIMIT_RST = SZ_W'(131072);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } state_t;

  // One dedup table entry as stored in memory
  typedef struct packed {
    logic [CKS_W-1:0] cks;
    logic [SZ_W-1:0]  size;
    logic [IDX_W-1:0] block;
    logic [SZ_W-1:0]  offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Placement decision from the open-block tracker
  typedef struct packed {
    logic             closed_valid;
    logic [IDX_W-1:0] closed_index;
    logic [SZ_W-1:0]  closed_fill;
    logic             closed_nc;
    logic [IDX_W-1:0] index;
    logic [SZ_W-1:0]  offset;
  } place_t;

  // One result item
  typedef struct packed {
    logic             is_duplicate;
    logic [IDX_W-1:0] place_index;
    logic [SZ_W-1:0]  place_offset;
    logic             closed_valid;
    logic [IDX_W-1:0] closed_index;
    logic [SZ_W-1:0]  closed_fill;
    logic             closed_no_compress;
    logic             table_full;
  } res_t;

endpackage

// ----- rtl/core/fdp_ram.sv -----
module fdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/fdp_place.sv -----
module fdp_place (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [fdp_pkg::SZ_W-1:0] max_size,
  input  logic [fdp_pkg::SZ_W-1:0] frag_size,
  input  logic                     frag_nc,
  input  logic                     commit,
  output fdp_pkg::place_t          place
);

  logic                      open_valid_r, open_valid_nxt;
  logic [fdp_pkg::IDX_W-1:0] open_index_r, open_index_nxt;
  logic [fdp_pkg::SZ_W-1:0]  open_fill_r, open_fill_nxt;
  logic                      open_nc_r, open_nc_nxt;
  logic [fdp_pkg::IDX_W-1:0] opened_r, opened_nxt;

  logic [fdp_pkg::SZ_W:0] fill_sum;
  logic                   close;
  logic                   fresh;

  // Decide whether the fragment fits in the open block
  always_comb begin
    fill_sum = {1'b0, open_fill_r} + {1'b0, frag_size};
    close    = open_valid_r && (fill_sum > {1'b0, max_size});
    fresh    = !open_valid_r || close;

    place.closed_valid = close;
    place.closed_index = close ? open_index_r : '0;
    place.closed_fill  = close ? open_fill_r : '0;
    place.closed_nc    = close ? open_nc_r : 1'b0;
    place.index        = fresh ? opened_r : open_index_r;
    place.offset       = fresh ? '0 : open_fill_r;
  end

  // Advance the open block on a committed placement
  always_comb begin
    open_valid_nxt = open_valid_r;
    open_index_nxt = open_index_r;
    open_fill_nxt  = open_fill_r;
    open_nc_nxt    = open_nc_r;
    opened_nxt     = opened_r;
    if (commit) begin
      open_valid_nxt = 1'b1;
      open_index_nxt = place.index;
      open_fill_nxt  = place.offset + frag_size;
      open_nc_nxt    = (fresh ? 1'b0 : open_nc_r) | frag_nc;
      if (fresh) begin
        opened_nxt = opened_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_valid_r <= 1'b0;
      open_index_r <= '0;
      open_fill_r  <= '0;
      open_nc_r    <= 1'b0;
      opened_r     <= '0;
    end else begin
      open_valid_r <= open_valid_nxt;
      open_index_r <= open_index_nxt;
      open_fill_r  <= open_fill_nxt;
      open_nc_r    <= open_nc_nxt;
      opened_r     <= opened_nxt;
    end
  end

endmodule

// ----- rtl/core/fragment_dedup_packer_unit.sv -----
// A fragment is taken in ST_IDLE; ST_SCAN then compares it with the table entries in use, in
// order. A hit ends the scan at that entry, a miss passes through ST_PLACE, and ST_DONE registers it.
// One fragment at a time: no new input is taken until the last result has moved to the output
// register. The search reads one table entry per cycle through the single read port of the table memory,
// and a finished result waits in ST_DONE while the previous one is still held for out_ready.
// Reset (rst_n, synchronous): empties the table, closes the open block, zeroes the
// block counter and restores the block size limit to 131072. Table memory is not cleared.
module fragment_dedup_packer_unit #(
  parameter int TABLE_DEPTH = fdp_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [fdp_pkg::SZ_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [fdp_pkg::CKS_W-1:0] in_frag_checksum,
  input  logic [fdp_pkg::SZ_W-1:0]  in_frag_size,
  input  logic                      in_no_compress,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_duplicate,
  output logic [fdp_pkg::IDX_W-1:0] out_place_index,
  output logic [fdp_pkg::SZ_W-1:0]  out_place_offset,
  output logic                      out_closed_valid,
  output logic [fdp_pkg::IDX_W-1:0] out_closed_index,
  output logic [fdp_pkg::SZ_W-1:0]  out_closed_fill,
  output logic                      out_closed_no_compress,
  output logic                      out_table_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  fdp_pkg::state_t state_r, state_nxt;

  logic [fdp_pkg::SZ_W-1:0]  max_r;
  logic [fdp_pkg::CKS_W-1:0] cks_r;
  logic [fdp_pkg::SZ_W-1:0]  size_r;
  logic                      nc_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             ptr_r;
  logic                      pend_r;
  fdp_pkg::res_t             res_r;
  fdp_pkg::res_t             res_nxt;
  fdp_pkg::res_t             out_r;
  logic                      out_valid_r;

  logic                      in_xfer;
  logic                      rd_en;
  logic                      commit;
  logic                      done;
  logic                      hit;
  logic                      full;
  fdp_pkg::entry_t           rd_entry;
  logic [fdp_pkg::ENTRY_W-1:0] rd_data;
  fdp_pkg::entry_t           wr_entry;
  fdp_pkg::place_t           place;

  assign in_xfer  = in_valid && in_ready;
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign rd_entry = fdp_pkg::entry_t'(rd_data);
  assign hit      = pend_r && (rd_entry.cks == cks_r) && (rd_entry.size == size_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdp_pkg::ST_IDLE:  if (in_valid) state_nxt = fdp_pkg::ST_SCAN;
      fdp_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = fdp_pkg::ST_DONE;
        end else if (!rd_en && !pend_r) begin
          state_nxt = fdp_pkg::ST_PLACE;
        end
      end
      fdp_pkg::ST_PLACE: state_nxt = fdp_pkg::ST_DONE;
      fdp_pkg::ST_DONE:  if (!out_valid_r || out_ready) state_nxt = fdp_pkg::ST_IDLE;
      default:           state_nxt = fdp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    commit   = 1'b0;
    done     = 1'b0;
    case (state_r)
      fdp_pkg::ST_IDLE:  in_ready = 1'b1;
      fdp_pkg::ST_SCAN:  rd_en = (ptr_r < count_r);
      fdp_pkg::ST_PLACE: commit = !full;
      fdp_pkg::ST_DONE:  done = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Table memory
  always_comb begin
    wr_entry.cks    = cks_r;
    wr_entry.size   = size_r;
    wr_entry.block  = place.index;
    wr_entry.offset = place.offset;
  end

  fdp_ram #(
    .WIDTH (fdp_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (commit),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Open block tracker
  fdp_place u_place (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_size  (max_r),
    .frag_size (size_r),
    .frag_nc   (nc_r),
    .commit    (commit),
    .place     (place)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdp_pkg::ST_IDLE;
      max_r       <= fdp_pkg::BLOCK_LIMIT_RST;
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (in_xfer) begin
        ptr_r <= '0;
      end else if (rd_en) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (commit) begin
        count_r <= count_r + 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Build the result from a duplicate hit, the placement decision or a full table
  always_comb begin
    res_nxt = res_r;
    if (state_r == fdp_pkg::ST_SCAN && hit) begin
      res_nxt              = '0;
      res_nxt.is_duplicate = 1'b1;
      res_nxt.place_index  = rd_entry.block;
      res_nxt.place_offset = rd_entry.offset;
    end else if (state_r == fdp_pkg::ST_PLACE) begin
      res_nxt = '0;
      if (full) begin
        res_nxt.table_full = 1'b1;
      end else begin
        res_nxt.place_index        = place.index;
        res_nxt.place_offset       = place.offset;
        res_nxt.closed_valid       = place.closed_valid;
        res_nxt.closed_index       = place.closed_index;
        res_nxt.closed_fill        = place.closed_fill;
        res_nxt.closed_no_compress = place.closed_nc;
      end
    end
  end

  // Hold the fragment and the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cks_r  <= in_frag_checksum;
      size_r <= in_frag_size;
      nc_r   <= in_no_compress;
    end
    res_r <= res_nxt;
    if (done) begin
      out_r <= res_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_is_duplicate       = out_r.is_duplicate;
  assign out_place_index        = out_r.place_index;
  assign out_place_offset       = out_r.place_offset;
  assign out_closed_valid       = out_r.closed_valid;
  assign out_closed_index       = out_r.closed_index;
  assign out_closed_fill        = out_r.closed_fill;
  assign out_closed_no_compress = out_r.closed_no_compress;
  assign out_table_full         = out_r.table_full;

endmodule
